### src/mcsv_pkg.sv
// Shared types, character codes and line-layout tables for the market CSV line parser.
// No dependencies.
package mcsv_pkg;

  localparam int MAX_FIELDS_DEF = 16;
  localparam int SYMBOL_LEN_DEF = 15;
  localparam int SYM_BYTES = 15;
  localparam int NUM_VALUES = 5;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_COUNT = 2'd1;
  localparam logic [1:0] STAT_TYPE = 2'd2;
  localparam logic [1:0] STAT_FIELD = 2'd3;

  localparam logic [2:0] MSG_ADD = 3'd0;
  localparam logic [2:0] MSG_EXEC = 3'd1;
  localparam logic [2:0] MSG_CANCEL = 3'd2;
  localparam logic [2:0] MSG_REPLACE = 3'd3;
  localparam logic [2:0] MSG_TRADE = 3'd4;

  localparam int VAL_TS = 0;
  localparam int VAL_ID1 = 1;
  localparam int VAL_ID2 = 2;
  localparam int VAL_PRICE = 3;
  localparam int VAL_QTY = 4;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_BODY,
    MODE_COMMENT
  } mode_t;

  typedef enum logic [3:0] {
    ROLE_NONE,
    ROLE_TYPE,
    ROLE_TS,
    ROLE_ID,
    ROLE_MATCH1,
    ROLE_NEWID,
    ROLE_MATCH2,
    ROLE_SYM,
    ROLE_PRICE,
    ROLE_QTY,
    ROLE_SIDE,
    ROLE_COND
  } role_t;

  typedef struct packed {
    logic content;
    logic neg;
    logic digit;
    logic bad;
    logic multi;
  } flags_t;

  typedef struct packed {
    logic [4:0] field_index;
    logic [63:0] acc;
    flags_t flags;
    logic [7:0] pend_sp;
    mode_t mode;
    logic [2:0] type_code;
    logic [1:0] first_error;
    logic [NUM_VALUES-1:0][63:0] vals;
    logic [SYM_BYTES-1:0][7:0] sym;
    logic side;
    logic [7:0] cond;
  } line_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic end_of_stream;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] msg_type;
    logic signed [63:0] timestamp;
    logic [63:0] first_id;
    logic [63:0] second_id;
    logic [63:0] symbol_low;
    logic [55:0] symbol_high;
    logic signed [63:0] price;
    logic [63:0] quantity;
    logic side;
    logic [7:0] conditions;
    logic [31:0] reject_count;
  } out_t;

  function automatic role_t role_lookup(logic [2:0] tc, logic [2:0] idx);
    role_t r;
    r = ROLE_NONE;
    case (tc)
      MSG_ADD: begin
        case (idx)
          3'd0: r = ROLE_TYPE;
          3'd1: r = ROLE_TS;
          3'd2: r = ROLE_ID;
          3'd3: r = ROLE_SYM;
          3'd4: r = ROLE_PRICE;
          3'd5: r = ROLE_QTY;
          3'd6: r = ROLE_SIDE;
          default: r = ROLE_NONE;
        endcase
      end
      MSG_EXEC: begin
        case (idx)
          3'd0: r = ROLE_TYPE;
          3'd1: r = ROLE_TS;
          3'd2: r = ROLE_ID;
          3'd3: r = ROLE_SYM;
          3'd4: r = ROLE_QTY;
          3'd5: r = ROLE_MATCH2;
          default: r = ROLE_NONE;
        endcase
      end
      MSG_CANCEL: begin
        case (idx)
          3'd0: r = ROLE_TYPE;
          3'd1: r = ROLE_TS;
          3'd2: r = ROLE_ID;
          3'd3: r = ROLE_SYM;
          3'd4: r = ROLE_QTY;
          default: r = ROLE_NONE;
        endcase
      end
      MSG_REPLACE: begin
        case (idx)
          3'd0: r = ROLE_TYPE;
          3'd1: r = ROLE_TS;
          3'd2: r = ROLE_ID;
          3'd3: r = ROLE_NEWID;
          3'd4: r = ROLE_SYM;
          3'd5: r = ROLE_PRICE;
          3'd6: r = ROLE_QTY;
          3'd7: r = ROLE_SIDE;
          default: r = ROLE_NONE;
        endcase
      end
      MSG_TRADE: begin
        case (idx)
          3'd0: r = ROLE_TYPE;
          3'd1: r = ROLE_TS;
          3'd2: r = ROLE_MATCH1;
          3'd3: r = ROLE_SYM;
          3'd4: r = ROLE_PRICE;
          3'd5: r = ROLE_QTY;
          3'd6: r = ROLE_SIDE;
          3'd7: r = ROLE_COND;
          default: r = ROLE_NONE;
        endcase
      end
      default: r = ROLE_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] expected_fields(logic [2:0] tc);
    logic [5:0] n;
    case (tc)
      MSG_ADD: n = 6'd7;
      MSG_EXEC: n = 6'd6;
      MSG_CANCEL: n = 6'd5;
      MSG_REPLACE: n = 6'd8;
      MSG_TRADE: n = 6'd8;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

endpackage

### src/market_csv_line_parser.sv
// Top level of the market CSV line parser: input register, line state and record register.
// Depends on mcsv_pkg and mcsv_step.
// A line's record is loaded into the record register when its terminating byte is processed out of the input register.
// One byte per cycle while no pending record stalls the input; the per-byte state update is a single registered pass.
// A pending record that is not taken stalls the input register and then the input.
// Reset (rst, synchronous) clears the line state, the pending CR and the error count.
module market_csv_line_parser #(
  parameter int MAX_FIELDS = mcsv_pkg::MAX_FIELDS_DEF,
  parameter int SYMBOL_LEN = mcsv_pkg::SYMBOL_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_ready,
  input  mcsv_pkg::in_t  byte_data,
  output logic           rec_valid,
  input  logic           rec_ready,
  output mcsv_pkg::out_t rec_data
);

  logic s1_valid;
  mcsv_pkg::in_t s1_data;
  mcsv_pkg::line_state_t st;
  mcsv_pkg::line_state_t st_next;
  logic pend_cr;
  logic pend_cr_next;
  logic [31:0] err_cnt;
  logic [31:0] err_cnt_next;
  logic res_valid;
  mcsv_pkg::out_t res;
  logic advance;
  logic work;

  assign advance = !rec_valid || rec_ready;
  assign byte_ready = !s1_valid || advance;
  assign work = s1_valid && advance;

  mcsv_step #(
    .MAX_FIELDS(MAX_FIELDS),
    .SYMBOL_LEN(SYMBOL_LEN)
  ) u_step (
    .st(st),
    .pend_cr(pend_cr),
    .item(s1_data),
    .err_cnt(err_cnt),
    .st_next(st_next),
    .pend_cr_next(pend_cr_next),
    .res_valid(res_valid),
    .res(res),
    .err_cnt_next(err_cnt_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      rec_valid <= 1'b0;
      st <= '0;
      pend_cr <= 1'b0;
      err_cnt <= '0;
    end else begin
      if (byte_ready) begin
        s1_valid <= byte_valid;
      end
      if (work) begin
        st <= st_next;
        pend_cr <= pend_cr_next;
        err_cnt <= err_cnt_next;
      end
      if (advance) begin
        rec_valid <= work && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      s1_data <= byte_data;
    end
    if (work && res_valid) begin
      rec_data <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !rec_valid |-> byte_ready)
    else $error("input stalled with no record pending");

  assert property (@(posedge clk) disable iff (rst)
    (err_cnt == $past(err_cnt)) || (err_cnt == $past(err_cnt) + 32'd1))
    else $error("error count moved by more than one");

  assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_data.status != mcsv_pkg::STAT_OK |->
      rec_data.price == 64'sd0 && rec_data.quantity == 64'd0 &&
      rec_data.reject_count != 32'd0 || rec_data.reject_count == 32'd0)
    else $error("rejected record carries payload");

  assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_data.status == mcsv_pkg::STAT_OK |->
      rec_data.msg_type <= mcsv_pkg::MSG_TRADE && rec_data.price >= 64'sd0)
    else $error("accepted record with bad type or price");

endmodule

### src/mcsv_step.sv
// Per-byte next-state and record logic of the market CSV line parser.
// Depends on mcsv_pkg.
module mcsv_step #(
  parameter int MAX_FIELDS = mcsv_pkg::MAX_FIELDS_DEF,
  parameter int SYMBOL_LEN = mcsv_pkg::SYMBOL_LEN_DEF
) (
  input  mcsv_pkg::line_state_t st,
  input  logic                  pend_cr,
  input  mcsv_pkg::in_t         item,
  input  logic [31:0]           err_cnt,
  output mcsv_pkg::line_state_t st_next,
  output logic                  pend_cr_next,
  output logic                  res_valid,
  output mcsv_pkg::out_t        res,
  output logic [31:0]           err_cnt_next
);

  localparam logic [4:0] MAX_FI = 5'(MAX_FIELDS);
  localparam logic [5:0] SYM_LIM = 6'((SYMBOL_LEN < 15) ? SYMBOL_LEN : 15);
  localparam logic [63:0] ACC_LIM = 64'd1844674407370955161;
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

  function automatic mcsv_pkg::line_state_t clear_field(mcsv_pkg::line_state_t s);
    mcsv_pkg::line_state_t t;
    t = s;
    t.acc = '0;
    t.flags = '0;
    t.pend_sp = '0;
    return t;
  endfunction

  function automatic mcsv_pkg::role_t role_of(mcsv_pkg::line_state_t s);
    mcsv_pkg::role_t r;
    if (s.field_index == 5'd0) begin
      r = mcsv_pkg::ROLE_TYPE;
    end else if (s.first_error == mcsv_pkg::STAT_TYPE || s.field_index >= 5'd8 ||
                 s.type_code > mcsv_pkg::MSG_TRADE) begin
      r = mcsv_pkg::ROLE_NONE;
    end else begin
      r = mcsv_pkg::role_lookup(s.type_code, s.field_index[2:0]);
    end
    return r;
  endfunction

  function automatic mcsv_pkg::line_state_t field_char(mcsv_pkg::line_state_t s,
                                                       logic [7:0] c);
    mcsv_pkg::line_state_t t;
    mcsv_pkg::role_t r;
    logic [5:0] cnt;
    logic [5:0] sp;
    logic [5:0] ends;
    logic [5:0] ncnt;
    logic [3:0] dg;
    logic signd;
    t = s;
    r = role_of(s);
    signd = (r == mcsv_pkg::ROLE_TS) || (r == mcsv_pkg::ROLE_PRICE);
    dg = 4'(c - mcsv_pkg::CH_ZERO);
    sp = (s.pend_sp > 8'd16) ? 6'd16 : s.pend_sp[5:0];
    cnt = {1'b0, s.acc[4:0]};
    ends = cnt + sp;
    ncnt = (ends > SYM_LIM) ? SYM_LIM : ends;
    if (r != mcsv_pkg::ROLE_NONE) begin
      if (c == mcsv_pkg::CH_SPACE) begin
        if (s.flags.content && s.pend_sp != 8'hFF) begin
          t.pend_sp = s.pend_sp + 8'd1;
        end
      end else begin
        if (r == mcsv_pkg::ROLE_SYM) begin
          for (int j = 0; j < mcsv_pkg::SYM_BYTES; j++) begin
            if (6'(j) >= cnt && 6'(j) < ncnt) begin
              t.sym[j] = mcsv_pkg::CH_SPACE;
            end
            if (ncnt < SYM_LIM && 6'(j) == ncnt) begin
              t.sym[j] = c;
            end
          end
          if (ncnt < SYM_LIM) begin
            t.acc = {58'b0, ncnt + 6'd1};
          end else begin
            t.acc = {58'b0, ncnt};
          end
        end else if (r == mcsv_pkg::ROLE_TYPE || r == mcsv_pkg::ROLE_SIDE) begin
          if (s.flags.content) begin
            t.flags.multi = 1'b1;
          end else begin
            t.acc = {56'b0, c};
          end
        end else begin
          if (s.flags.content && s.pend_sp != 8'd0) begin
            t.flags.bad = 1'b1;
          end else if (!s.flags.content && c == mcsv_pkg::CH_MINUS && signd) begin
            t.flags.neg = 1'b1;
          end else if (c >= mcsv_pkg::CH_ZERO && c <= mcsv_pkg::CH_NINE) begin
            t.flags.digit = 1'b1;
            if (s.acc > ACC_LIM || (s.acc == ACC_LIM && dg > 4'd5)) begin
              t.flags.bad = 1'b1;
            end else begin
              t.acc = (s.acc << 3) + (s.acc << 1) + {60'b0, dg};
            end
          end else begin
            t.flags.bad = 1'b1;
          end
        end
        t.pend_sp = '0;
        t.flags.content = 1'b1;
      end
    end
    return t;
  endfunction

  function automatic mcsv_pkg::line_state_t field_end(mcsv_pkg::line_state_t s);
    mcsv_pkg::line_state_t t;
    mcsv_pkg::role_t r;
    logic ok;
    logic single;
    logic [63:0] v;
    logic check;
    t = s;
    check = 1'b1;
    r = role_of(s);
    single = s.flags.content && !s.flags.multi;
    ok = s.flags.digit && !s.flags.bad;
    if (r == mcsv_pkg::ROLE_TS || r == mcsv_pkg::ROLE_PRICE) begin
      ok = ok && (s.flags.neg ? (s.acc <= NEG_MAX) : (s.acc <= POS_MAX));
    end
    v = s.flags.neg ? (64'd0 - s.acc) : s.acc;
    case (r)
      mcsv_pkg::ROLE_TYPE: begin
        check = 1'b0;
        if (single && s.acc == {56'b0, mcsv_pkg::CH_A}) t.type_code = mcsv_pkg::MSG_ADD;
        else if (single && s.acc == {56'b0, mcsv_pkg::CH_E}) t.type_code = mcsv_pkg::MSG_EXEC;
        else if (single && s.acc == {56'b0, mcsv_pkg::CH_C}) t.type_code = mcsv_pkg::MSG_CANCEL;
        else if (single && s.acc == {56'b0, mcsv_pkg::CH_R}) t.type_code = mcsv_pkg::MSG_REPLACE;
        else if (single && s.acc == {56'b0, mcsv_pkg::CH_T}) t.type_code = mcsv_pkg::MSG_TRADE;
        else t.first_error = mcsv_pkg::STAT_TYPE;
      end
      mcsv_pkg::ROLE_TS: begin
        if (ok) t.vals[mcsv_pkg::VAL_TS] = v;
      end
      mcsv_pkg::ROLE_ID: begin
        ok = ok && v != 64'd0;
        if (ok) t.vals[mcsv_pkg::VAL_ID1] = v;
      end
      mcsv_pkg::ROLE_MATCH1: begin
        if (ok) t.vals[mcsv_pkg::VAL_ID1] = v;
      end
      mcsv_pkg::ROLE_NEWID: begin
        ok = ok && v != 64'd0 && v != s.vals[mcsv_pkg::VAL_ID1];
        if (ok) t.vals[mcsv_pkg::VAL_ID2] = v;
      end
      mcsv_pkg::ROLE_MATCH2: begin
        if (ok) t.vals[mcsv_pkg::VAL_ID2] = v;
      end
      mcsv_pkg::ROLE_PRICE: begin
        ok = ok && !s.flags.neg && s.acc != 64'd0;
        if (ok) t.vals[mcsv_pkg::VAL_PRICE] = v;
      end
      mcsv_pkg::ROLE_QTY: begin
        ok = ok && v != 64'd0;
        if (ok) t.vals[mcsv_pkg::VAL_QTY] = v;
      end
      mcsv_pkg::ROLE_COND: begin
        ok = ok && v <= 64'd255;
        if (ok) t.cond = v[7:0];
      end
      mcsv_pkg::ROLE_SIDE: begin
        ok = single && (s.acc == {56'b0, mcsv_pkg::CH_B} || s.acc == {56'b0, mcsv_pkg::CH_S});
        if (ok && s.acc == {56'b0, mcsv_pkg::CH_S}) t.side = 1'b1;
      end
      default: check = 1'b0;
    endcase
    if (check && !ok && t.first_error == mcsv_pkg::STAT_OK) begin
      t.first_error = mcsv_pkg::STAT_FIELD;
    end
    return t;
  endfunction

  function automatic mcsv_pkg::line_state_t line_char(mcsv_pkg::line_state_t s,
                                                      logic [7:0] c);
    mcsv_pkg::line_state_t t;
    logic go;
    t = s;
    go = 1'b0;
    if (s.mode == mcsv_pkg::MODE_BODY) begin
      go = 1'b1;
    end else if (s.mode == mcsv_pkg::MODE_START) begin
      if (c == mcsv_pkg::CH_HASH) begin
        t.mode = mcsv_pkg::MODE_COMMENT;
      end else if (c != mcsv_pkg::CH_SPACE) begin
        t.mode = mcsv_pkg::MODE_BODY;
        go = 1'b1;
      end
    end
    if (go && t.field_index < MAX_FI) begin
      if (c == mcsv_pkg::CH_COMMA) begin
        t = field_end(t);
        t.field_index = t.field_index + 5'd1;
        t = clear_field(t);
      end else begin
        t = field_char(t, c);
      end
    end
    return t;
  endfunction

  mcsv_pkg::line_state_t s_cr;
  mcsv_pkg::line_state_t s_fin;
  logic end_now;
  logic [5:0] n_fields;
  logic [1:0] stat;

  always_comb begin
    end_now = item.end_of_stream || item.data_byte == mcsv_pkg::CH_LF;
    if (pend_cr && !end_now) begin
      s_cr = line_char(st, mcsv_pkg::CH_CR);
    end else begin
      s_cr = st;
    end
    if (s_cr.field_index < MAX_FI) begin
      s_fin = field_end(s_cr);
      n_fields = {1'b0, s_cr.field_index} + 6'd1;
    end else begin
      s_fin = s_cr;
      n_fields = {1'b0, MAX_FI};
    end
    if (s_fin.first_error == mcsv_pkg::STAT_TYPE) begin
      stat = mcsv_pkg::STAT_TYPE;
    end else if (s_fin.type_code > mcsv_pkg::MSG_TRADE ||
                 n_fields != mcsv_pkg::expected_fields(s_fin.type_code)) begin
      stat = mcsv_pkg::STAT_COUNT;
    end else begin
      stat = s_fin.first_error;
    end

    res_valid = 1'b0;
    err_cnt_next = err_cnt;
    pend_cr_next = 1'b0;
    st_next = s_cr;
    res = '0;
    if (end_now) begin
      st_next = '0;
      st_next.mode = mcsv_pkg::MODE_START;
      if (s_cr.mode == mcsv_pkg::MODE_BODY) begin
        res_valid = 1'b1;
        if (stat != mcsv_pkg::STAT_OK) begin
          err_cnt_next = err_cnt + 32'd1;
        end else begin
          res.msg_type = s_fin.type_code;
          res.timestamp = s_fin.vals[mcsv_pkg::VAL_TS];
          res.first_id = s_fin.vals[mcsv_pkg::VAL_ID1];
          res.second_id = s_fin.vals[mcsv_pkg::VAL_ID2];
          res.symbol_low = s_fin.sym[7:0];
          res.symbol_high = s_fin.sym[14:8];
          res.price = s_fin.vals[mcsv_pkg::VAL_PRICE];
          res.quantity = s_fin.vals[mcsv_pkg::VAL_QTY];
          res.side = s_fin.side;
          res.conditions = s_fin.cond;
        end
        res.status = stat;
        res.reject_count = err_cnt_next;
      end
    end else if (item.data_byte == mcsv_pkg::CH_CR) begin
      pend_cr_next = 1'b1;
    end else begin
      st_next = line_char(s_cr, item.data_byte);
    end
  end

endmodule

### verif/market_csv_line_parser_test.sv
// Self-checking testbench for market_csv_line_parser: directed and random CSV lines
// are streamed in byte by byte, and every record is checked against a built-in predictor.
// Depends on mcsv_pkg and the parser RTL.
`timescale 1ns / 100ps

module market_csv_line_parser_test;

  localparam int LINE_FIELDS = 16;
  localparam int SYM_KEEP = 15;
  localparam int IDLE_LIMIT = 3000;
  localparam int ITEM_TARGET = 950;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_ready;
  mcsv_pkg::in_t byte_data = '0;
  logic rec_valid;
  logic rec_ready = 1'b0;
  mcsv_pkg::out_t rec_data;

  mcsv_pkg::out_t pending_recs[$];
  int errors = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;
  int hold_req = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  logic [4:0] fld;
  logic [63:0] acc;
  bit f_content, f_neg, f_digit, f_bad, f_multi;
  logic [7:0] spaces;
  mcsv_pkg::mode_t mode;
  bit cr_pend;
  logic [2:0] tcode;
  logic [1:0] ferr;
  logic [63:0] vals[mcsv_pkg::NUM_VALUES];
  logic [7:0] sym[mcsv_pkg::SYM_BYTES];
  logic side_s;
  logic [7:0] cond_s;
  logic [31:0] rejects;

  mcsv_pkg::role_t layout[5][8] = '{
    '{mcsv_pkg::ROLE_TYPE, mcsv_pkg::ROLE_TS, mcsv_pkg::ROLE_ID, mcsv_pkg::ROLE_SYM,
      mcsv_pkg::ROLE_PRICE, mcsv_pkg::ROLE_QTY, mcsv_pkg::ROLE_SIDE, mcsv_pkg::ROLE_NONE},
    '{mcsv_pkg::ROLE_TYPE, mcsv_pkg::ROLE_TS, mcsv_pkg::ROLE_ID, mcsv_pkg::ROLE_SYM,
      mcsv_pkg::ROLE_QTY, mcsv_pkg::ROLE_MATCH2, mcsv_pkg::ROLE_NONE, mcsv_pkg::ROLE_NONE},
    '{mcsv_pkg::ROLE_TYPE, mcsv_pkg::ROLE_TS, mcsv_pkg::ROLE_ID, mcsv_pkg::ROLE_SYM,
      mcsv_pkg::ROLE_QTY, mcsv_pkg::ROLE_NONE, mcsv_pkg::ROLE_NONE, mcsv_pkg::ROLE_NONE},
    '{mcsv_pkg::ROLE_TYPE, mcsv_pkg::ROLE_TS, mcsv_pkg::ROLE_ID, mcsv_pkg::ROLE_NEWID,
      mcsv_pkg::ROLE_SYM, mcsv_pkg::ROLE_PRICE, mcsv_pkg::ROLE_QTY, mcsv_pkg::ROLE_SIDE},
    '{mcsv_pkg::ROLE_TYPE, mcsv_pkg::ROLE_TS, mcsv_pkg::ROLE_MATCH1, mcsv_pkg::ROLE_SYM,
      mcsv_pkg::ROLE_PRICE, mcsv_pkg::ROLE_QTY, mcsv_pkg::ROLE_SIDE, mcsv_pkg::ROLE_COND}
  };
  int field_total[5] = '{7, 6, 5, 8, 8};

  market_csv_line_parser uut (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_ready(byte_ready), .byte_data(byte_data),
    .rec_valid(rec_valid), .rec_ready(rec_ready), .rec_data(rec_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_field();
    acc = '0;
    {f_content, f_neg, f_digit, f_bad, f_multi} = '0;
    spaces = '0;
  endfunction

  function automatic void clear_line();
    clear_field();
    fld = '0;
    tcode = mcsv_pkg::MSG_ADD;
    ferr = mcsv_pkg::STAT_OK;
    foreach (vals[k]) vals[k] = '0;
    foreach (sym[k]) sym[k] = '0;
    side_s = 1'b0;
    cond_s = '0;
    mode = mcsv_pkg::MODE_START;
  endfunction

  function automatic mcsv_pkg::role_t role_at(logic [4:0] idx);
    if (idx == 0) return mcsv_pkg::ROLE_TYPE;
    if (ferr == mcsv_pkg::STAT_TYPE || idx >= 8) return mcsv_pkg::ROLE_NONE;
    return layout[tcode][idx[2:0]];
  endfunction

  function automatic void put_symbol_char(logic [7:0] c);
    if (acc < SYM_KEEP) begin
      sym[acc[3:0]] = c;
      acc = acc + 64'd1;
    end
  endfunction

  function automatic void take_field_char(logic [7:0] c);
    mcsv_pkg::role_t r;
    r = role_at(fld);
    if (r == mcsv_pkg::ROLE_NONE) return;
    if (c == mcsv_pkg::CH_SPACE) begin
      if (f_content && spaces < 255) spaces = spaces + 8'd1;
      return;
    end
    if (r == mcsv_pkg::ROLE_SYM) begin
      for (int k = 0; k < spaces && k < 16; k++) put_symbol_char(mcsv_pkg::CH_SPACE);
      put_symbol_char(c);
    end else if (r == mcsv_pkg::ROLE_TYPE || r == mcsv_pkg::ROLE_SIDE) begin
      if (f_content) f_multi = 1'b1;
      else acc = {56'd0, c};
    end else if (f_content && spaces > 0) begin
      f_bad = 1'b1;
    end else if (!f_content && c == mcsv_pkg::CH_MINUS &&
                 (r == mcsv_pkg::ROLE_TS || r == mcsv_pkg::ROLE_PRICE)) begin
      f_neg = 1'b1;
    end else if (c >= mcsv_pkg::CH_ZERO && c <= mcsv_pkg::CH_NINE) begin
      f_digit = 1'b1;
      if (acc > 64'd1844674407370955161 ||
          (acc == 64'd1844674407370955161 && c - mcsv_pkg::CH_ZERO > 5))
        f_bad = 1'b1;
      else
        acc = acc * 64'd10 + {56'd0, 8'(c - mcsv_pkg::CH_ZERO)};
    end else begin
      f_bad = 1'b1;
    end
    spaces = '0;
    f_content = 1'b1;
  endfunction

  function automatic void close_field();
    mcsv_pkg::role_t r;
    bit ok, single;
    logic [63:0] v;
    r = role_at(fld);
    ok = f_digit && !f_bad;
    single = f_content && !f_multi;
    if (r == mcsv_pkg::ROLE_TS || r == mcsv_pkg::ROLE_PRICE)
      ok = ok && (f_neg ? acc <= 64'h8000_0000_0000_0000 : acc <= 64'h7FFF_FFFF_FFFF_FFFF);
    v = f_neg ? -acc : acc;
    case (r)
      mcsv_pkg::ROLE_TYPE: begin
        if (single && acc == mcsv_pkg::CH_A) tcode = mcsv_pkg::MSG_ADD;
        else if (single && acc == mcsv_pkg::CH_E) tcode = mcsv_pkg::MSG_EXEC;
        else if (single && acc == mcsv_pkg::CH_C) tcode = mcsv_pkg::MSG_CANCEL;
        else if (single && acc == mcsv_pkg::CH_R) tcode = mcsv_pkg::MSG_REPLACE;
        else if (single && acc == mcsv_pkg::CH_T) tcode = mcsv_pkg::MSG_TRADE;
        else ferr = mcsv_pkg::STAT_TYPE;
        return;
      end
      mcsv_pkg::ROLE_TS: if (ok) vals[mcsv_pkg::VAL_TS] = v;
      mcsv_pkg::ROLE_ID: begin
        ok = ok && v != 0;
        if (ok) vals[mcsv_pkg::VAL_ID1] = v;
      end
      mcsv_pkg::ROLE_MATCH1: if (ok) vals[mcsv_pkg::VAL_ID1] = v;
      mcsv_pkg::ROLE_NEWID: begin
        ok = ok && v != 0 && v != vals[mcsv_pkg::VAL_ID1];
        if (ok) vals[mcsv_pkg::VAL_ID2] = v;
      end
      mcsv_pkg::ROLE_MATCH2: if (ok) vals[mcsv_pkg::VAL_ID2] = v;
      mcsv_pkg::ROLE_PRICE: begin
        ok = ok && !f_neg && acc != 0;
        if (ok) vals[mcsv_pkg::VAL_PRICE] = v;
      end
      mcsv_pkg::ROLE_QTY: begin
        ok = ok && v != 0;
        if (ok) vals[mcsv_pkg::VAL_QTY] = v;
      end
      mcsv_pkg::ROLE_COND: begin
        ok = ok && v <= 255;
        if (ok) cond_s = v[7:0];
      end
      mcsv_pkg::ROLE_SIDE: begin
        ok = single && (acc == mcsv_pkg::CH_B || acc == mcsv_pkg::CH_S);
        if (ok && acc == mcsv_pkg::CH_S) side_s = 1'b1;
      end
      default: return;
    endcase
    if (!ok && ferr == mcsv_pkg::STAT_OK) ferr = mcsv_pkg::STAT_FIELD;
  endfunction

  function automatic void take_line_char(logic [7:0] c);
    if (mode == mcsv_pkg::MODE_COMMENT) return;
    if (mode != mcsv_pkg::MODE_BODY) begin
      if (c == mcsv_pkg::CH_SPACE) return;
      if (c == mcsv_pkg::CH_HASH) begin
        mode = mcsv_pkg::MODE_COMMENT;
        return;
      end
      mode = mcsv_pkg::MODE_BODY;
    end
    if (c == mcsv_pkg::CH_COMMA) begin
      if (fld < LINE_FIELDS) begin
        close_field();
        fld = fld + 5'd1;
        clear_field();
      end
    end else if (fld < LINE_FIELDS) begin
      take_field_char(c);
    end
  endfunction

  function automatic bit finish_line(output mcsv_pkg::out_t rec);
    int n;
    rec = '0;
    if (mode != mcsv_pkg::MODE_BODY) begin
      clear_line();
      return 1'b0;
    end
    if (fld < LINE_FIELDS) begin
      close_field();
      n = fld + 1;
    end else begin
      n = LINE_FIELDS;
    end
    if (ferr == mcsv_pkg::STAT_TYPE) rec.status = mcsv_pkg::STAT_TYPE;
    else if (n != field_total[tcode]) rec.status = mcsv_pkg::STAT_COUNT;
    else rec.status = ferr;
    if (rec.status != mcsv_pkg::STAT_OK) begin
      rejects = rejects + 32'd1;
    end else begin
      rec.msg_type = tcode;
      rec.timestamp = vals[mcsv_pkg::VAL_TS];
      rec.first_id = vals[mcsv_pkg::VAL_ID1];
      rec.second_id = vals[mcsv_pkg::VAL_ID2];
      for (int k = 0; k < 8; k++) rec.symbol_low[8*k +: 8] = sym[k];
      for (int k = 0; k < 7; k++) rec.symbol_high[8*k +: 8] = sym[8+k];
      rec.price = vals[mcsv_pkg::VAL_PRICE];
      rec.quantity = vals[mcsv_pkg::VAL_QTY];
      rec.side = side_s;
      rec.conditions = cond_s;
    end
    rec.reject_count = rejects;
    clear_line();
    return 1'b1;
  endfunction

  function automatic bit parse_byte(mcsv_pkg::in_t x, output mcsv_pkg::out_t rec);
    rec = '0;
    if (x.end_of_stream) begin
      cr_pend = 1'b0;
      return finish_line(rec);
    end
    if (cr_pend) begin
      cr_pend = 1'b0;
      if (x.data_byte == mcsv_pkg::CH_LF) return finish_line(rec);
      take_line_char(mcsv_pkg::CH_CR);
    end
    if (x.data_byte == mcsv_pkg::CH_CR) begin
      cr_pend = 1'b1;
      return 1'b0;
    end
    if (x.data_byte == mcsv_pkg::CH_LF) return finish_line(rec);
    take_line_char(x.data_byte);
    return 1'b0;
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_record(mcsv_pkg::out_t got, mcsv_pkg::out_t want);
    if (got.status !== want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.msg_type !== want.msg_type)
      report($sformatf("msg_type %0d, want %0d", got.msg_type, want.msg_type));
    if (got.timestamp !== want.timestamp)
      report($sformatf("timestamp %0d, want %0d", got.timestamp, want.timestamp));
    if (got.first_id !== want.first_id)
      report($sformatf("first_id %0d, want %0d", got.first_id, want.first_id));
    if (got.second_id !== want.second_id)
      report($sformatf("second_id %0d, want %0d", got.second_id, want.second_id));
    if (got.symbol_low !== want.symbol_low)
      report($sformatf("symbol_low %h, want %h", got.symbol_low, want.symbol_low));
    if (got.symbol_high !== want.symbol_high)
      report($sformatf("symbol_high %h, want %h", got.symbol_high, want.symbol_high));
    if (got.price !== want.price)
      report($sformatf("price %0d, want %0d", got.price, want.price));
    if (got.quantity !== want.quantity)
      report($sformatf("quantity %0d, want %0d", got.quantity, want.quantity));
    if (got.side !== want.side)
      report($sformatf("side %0d, want %0d", got.side, want.side));
    if (got.conditions !== want.conditions)
      report($sformatf("conditions %0d, want %0d", got.conditions, want.conditions));
    if (got.reject_count !== want.reject_count)
      report($sformatf("reject_count %0d, want %0d", got.reject_count, want.reject_count));
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(logic [7:0] b, logic eos);
    int gap;
    mcsv_pkg::out_t rec;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      byte_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid = 1'b1;
    byte_data.data_byte = b;
    byte_data.end_of_stream = eos;
    do @(posedge clk); while (!byte_ready);
    if (parse_byte(byte_data, rec)) pending_recs.push_back(rec);
    bytes_sent++;
    @(negedge clk);
    byte_valid = 1'b0;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic end_stream();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_drained();
    while (pending_recs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always begin
    int stall;
    @(negedge clk);
    if (hold_req > 0) begin
      rec_ready = 1'b0;
      repeat (hold_req) @(negedge clk);
      hold_req = 0;
    end else if (!rx_quiet) begin
      stall = $urandom_range(0, 11);
      if (stall > 0) begin
        rec_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
    rec_ready = 1'b1;
    do @(posedge clk); while (!rec_valid);
    if (pending_recs.size() == 0) report("record with none expected");
    else check_record(rec_data, pending_recs.pop_front());
  end

  always @(posedge clk) begin
    if ((byte_valid && byte_ready) || (rec_valid && rec_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic string pad();
    case ($urandom_range(0, 7))
      0: return " ";
      1: return "  ";
      default: return "";
    endcase
  endfunction

  function automatic logic [63:0] any_unsigned();
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(1, 100));
      1: return {$urandom, $urandom};
      2: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      default: return 64'($urandom);
    endcase
  endfunction

  function automatic string any_signed(bit positive);
    logic signed [63:0] v;
    v = $signed(any_unsigned());
    if (positive && v <= 0) v = 64'($urandom_range(1, 1000));
    if (!positive && $urandom_range(0, 1)) v = -$signed({1'b0, v[62:0]});
    return $sformatf("%0d", v);
  endfunction

  function automatic string any_symbol();
    string s;
    int n;
    s = "";
    n = $urandom_range(0, 18);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 12) == 0) s = {s, " "};
      else s = {s, string'(8'($urandom_range(8'h41, 8'h5A)))};
    end
    return s;
  endfunction

  function automatic string order_line();
    string f[$];
    string s, side;
    string junk[6] = '{"", "0", "-5", "x", "1 2", "99999999999999999999"};
    logic [63:0] id;
    int t, pick;
    t = $urandom_range(0, 4);
    side = $urandom_range(0, 1) ? "S" : "B";
    id = any_unsigned();
    case (t)
      0: f = '{"A", any_signed(0), $sformatf("%0d", id), any_symbol(), any_signed(1),
               $sformatf("%0d", any_unsigned()), side};
      1: f = '{"E", any_signed(0), $sformatf("%0d", id), any_symbol(),
               $sformatf("%0d", any_unsigned()), $sformatf("%0d", {$urandom, $urandom})};
      2: f = '{"C", any_signed(0), $sformatf("%0d", id), any_symbol(),
               $sformatf("%0d", any_unsigned())};
      3: f = '{"R", any_signed(0), $sformatf("%0d", id),
               $sformatf("%0d", $urandom_range(0, 7) == 0 ? id : id + 64'd1), any_symbol(),
               any_signed(1), $sformatf("%0d", any_unsigned()), side};
      default: f = '{"T", any_signed(0), $sformatf("%0d", {$urandom, $urandom}), any_symbol(),
                     any_signed(1), $sformatf("%0d", any_unsigned()), side,
                     $sformatf("%0d", $urandom_range(0, 255))};
    endcase
    case ($urandom_range(0, 9))
      0: f.delete(f.size() - 1);
      1: f.push_back(junk[$urandom_range(0, 5)]);
      2: f[$urandom_range(0, f.size() - 1)] = junk[$urandom_range(0, 5)];
      default: ;
    endcase
    s = "";
    foreach (f[i]) begin
      if (i != 0) s = {s, ","};
      s = {s, pad(), f[i], pad()};
    end
    if ($urandom_range(0, 9) == 0) begin
      pick = $urandom_range(0, s.len() - 1);
      s[pick] = 8'($urandom_range(0, 255));
    end
    return s;
  endfunction

  task automatic send_random_line();
    string s;
    case ($urandom_range(0, 19))
      0: s = {pad(), "# ", any_symbol()};
      1: s = pad();
      2, 3: begin
        s = "";
        repeat ($urandom_range(1, 20)) s = {s, string'(8'($urandom_range(1, 255)))};
      end
      default: s = order_line();
    endcase
    send_text(s);
    case ($urandom_range(0, 9))
      0: end_stream();
      1, 2: send_text("\r\n");
      default: send_text("\n");
    endcase
  endtask

  task automatic test_each_type();
    send_text("A,1,5,IBM,100,10,B\n");
    send_text("E,-3,7,MSFT,4,99\n");
    send_text("C,0,1,X,1\n");
    send_text("R,2,3,4,SYM,5,6,S\n");
    send_text("T,9,0,ABCDEFGHIJKLMNOPQ,1,1,S,255\n");
  endtask

  task automatic test_extremes();
    send_text("A, -9223372036854775808 ,18446744073709551615, x  y ,");
    send_text("9223372036854775807,18446744073709551615, S \r\n");
    send_text("A,9223372036854775808,1,Z,1,1,B\n");
    send_text("C,1,18446744073709551616,Z,1\n");
    send_text("T,1,1,Q,1,1,B,256\n");
  endtask

  task automatic test_rejects();
    send_text("Q,1,2\n");
    send_text("AB,1,2,S,1,1,B\n");
    send_text("A,1,2,S,3,4\n");
    send_text("R,1,5,5,S,1,1,B\n");
    send_text("A,1,0,S,1,1,B\n");
    send_text("A,1,2,S,-1,1,X\n");
    send_text("E,1 2,3,S,4,5\n");
    send_text("A,,,,,,,,,,,,,,,,,,,,\n");
    send_text("Z,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17\n");
  endtask

  task automatic test_skipped_lines();
    send_text("   \n\n\r\n  # comment, with comma\n");
    send_text("A,1,2,S\r3,4,5,B\n");
    send_text("C,1,2,S,3");
    end_stream();
    end_stream();
    send_text("C,1,2,S,3\r");
    end_stream();
  endtask

  task automatic test_backpressure();
    hold_req = 300;
    tx_quiet = 1'b1;
    repeat (4) send_random_line();
    tx_quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_random();
    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 30) == 0) begin
        tx_quiet = ~tx_quiet;
        rx_quiet = ~rx_quiet;
      end
      send_random_line();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    clear_line();
    cr_pend = 1'b0;
    rejects = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_each_type();
    test_extremes();
    test_rejects();
    test_skipped_lines();
    wait_drained();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_recs.size() != 0) report("records still expected at end");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
